/* rtl/ppp_pkg.sv */
// Shared types and constants for the perspective point projector.
package ppp_pkg;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;
    localparam int unsigned CFG_INDEX_W       = 3;
    localparam int unsigned CFG_DATA_W        = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW0_LO = 3'd0,
        REG_ROW0_HI = 3'd1,
        REG_ROW1_LO = 3'd2,
        REG_ROW1_HI = 3'd3,
        REG_ROW3_LO = 3'd4,
        REG_ROW3_HI = 3'd5,
        REG_SCREEN  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               visible;
    } screen_t;

endpackage

/* rtl/perspective_point_projector.sv */
// Pipelined world-to-screen projection of one point per cycle.
//
// Channel   Signals                                 Handshake
// ------    -------------------------------------   ---------------------------------
// point     start, busy, point                      request taken when start && !busy
// result    done, result                            one-cycle strobe, cannot be held off
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  write when valid && ready
//
// A point may enter in every cycle; busy is always low.
// Each request, once taken, passes through the stages for matrix
// multiply, clip sum, setup, scaling, range check and one stage per
// quotient bit of the 33-bit divider.
// Reset clears the pipeline valid bits and the configuration registers.
module perspective_point_projector #(
    parameter int unsigned FRAC_BITS = ppp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ppp_pkg::point_t                     point,
    output logic                                done,
    output ppp_pkg::screen_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ppp_pkg::*;

    localparam int unsigned SUM_W = 66;
    localparam int unsigned CW    = SUM_W - FRAC_BITS;
    localparam int unsigned AW    = CW + 1;
    localparam int unsigned DW    = AW;
    localparam int unsigned NW    = AW + 16 + FRAC_BITS;
    localparam int unsigned QB    = 33;
    localparam int unsigned XW    = NW + DW;
    localparam int unsigned TW    = FRAC_BITS + 10;
    localparam int unsigned LAT   = QB + 6;

    // ---------------- configuration ----------------
    logic [63:0] mat_reg [0:5];
    logic [31:0] screen_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mat_reg[i] <= '0;
            end
            screen_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW0_LO: mat_reg[0] <= cfg_data;
                REG_ROW0_HI: mat_reg[1] <= cfg_data;
                REG_ROW1_LO: mat_reg[2] <= cfg_data;
                REG_ROW1_HI: mat_reg[3] <= cfg_data;
                REG_ROW3_LO: mat_reg[4] <= cfg_data;
                REG_ROW3_HI: mat_reg[5] <= cfg_data;
                REG_SCREEN:  screen_reg <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    logic signed [31:0] m [0:2][0:3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            m[r][0] = mat_reg[2*r][31:0];
            m[r][1] = mat_reg[2*r][63:32];
            m[r][2] = mat_reg[2*r+1][31:0];
            m[r][3] = mat_reg[2*r+1][63:32];
        end
    end

    // ---------------- stage 1: products ----------------
    logic               s1_valid_reg;
    logic signed [63:0] prod_reg [0:2][0:2];
    logic signed [31:0] pin [0:2];

    assign pin[0] = point.point_x;
    assign pin[1] = point.point_y;
    assign pin[2] = point.point_z;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= 64'(m[r][c]) * 64'(pin[c]);
            end
        end
    end

    // ---------------- stage 2: clip sums ----------------
    logic                s2_valid_reg;
    logic signed [CW-1:0] clip_reg [0:2];
    logic signed [SUM_W-1:0] sum_next [0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]) + (SUM_W'(m[r][3]) <<< FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            clip_reg[r] <= sum_next[r][SUM_W-1:FRAC_BITS];
        end
    end

    // ---------------- stage 3: threshold and setup ----------------
    logic signed [CW-1:0] cx, cy, cw;
    logic                 w_nonpos, w_below_one, behind_next;
    logic [TW-1:0]        w_scaled;
    logic signed [AW-1:0] ax, ay;

    assign cx = clip_reg[0];
    assign cy = clip_reg[1];
    assign cw = clip_reg[2];
    assign w_nonpos    = cw[CW-1] || (cw == '0);
    assign w_below_one = (cw[CW-1:FRAC_BITS] == '0);
    assign w_scaled    = TW'(cw[FRAC_BITS-1:0]) * TW'(10'd1000);
    assign behind_next = w_nonpos || (w_below_one && (w_scaled[TW-1:FRAC_BITS] == '0));
    assign ax = AW'(cw) + AW'(cx);
    assign ay = AW'(cw) - AW'(cy);

    function automatic logic [31:0] scale_behind(input logic signed [CW-1:0] v);
        logic signed [33:0] p;
        begin
            p = 34'($signed(v[16:0])) * 34'(18'sd100000);
            if (v > CW'(21474))
                scale_behind = 32'h7fff_ffff;
            else if (v < -CW'(21474))
                scale_behind = 32'h8000_0000;
            else
                scale_behind = p[31:0];
        end
    endfunction

    logic          s3_valid_reg, s3_behind_reg;
    logic [31:0]   s3_bx_reg, s3_by_reg;
    logic          s3_negx_reg, s3_negy_reg;
    logic [AW-1:0] s3_magx_reg, s3_magy_reg;
    logic [DW-1:0] s3_d_reg;

    always_ff @(posedge clk)
    begin
        s3_behind_reg <= behind_next;
        s3_bx_reg     <= scale_behind(cx);
        s3_by_reg     <= scale_behind(cy);
        s3_negx_reg   <= ax[AW-1];
        s3_negy_reg   <= ay[AW-1];
        s3_magx_reg   <= ax[AW-1] ? AW'(-ax) : AW'(ax);
        s3_magy_reg   <= ay[AW-1] ? AW'(-ay) : AW'(ay);
        s3_d_reg      <= DW'(cw) << 1;
    end

    // ---------------- stage 4: numerators ----------------
    logic          s4_valid_reg, s4_behind_reg, s4_negx_reg, s4_negy_reg;
    logic [31:0]   s4_bx_reg, s4_by_reg;
    logic [NW-1:0] s4_nx_reg, s4_ny_reg;
    logic [DW-1:0] s4_d_reg;
    logic [AW+15:0] nx_prod, ny_prod;

    assign nx_prod = (AW+16)'(s3_magx_reg) * (AW+16)'(screen_reg[15:0]);
    assign ny_prod = (AW+16)'(s3_magy_reg) * (AW+16)'(screen_reg[31:16]);

    always_ff @(posedge clk)
    begin
        s4_behind_reg <= s3_behind_reg;
        s4_bx_reg     <= s3_bx_reg;
        s4_by_reg     <= s3_by_reg;
        s4_negx_reg   <= s3_negx_reg;
        s4_negy_reg   <= s3_negy_reg;
        s4_nx_reg     <= {nx_prod, {FRAC_BITS{1'b0}}};
        s4_ny_reg     <= {ny_prod, {FRAC_BITS{1'b0}}};
        s4_d_reg      <= s3_d_reg;
    end

    // ---------------- divider: range check then one bit per stage ----------------
    logic          dv_valid_reg  [0:QB];
    logic          dv_behind_reg [0:QB];
    logic          dv_negx_reg   [0:QB];
    logic          dv_negy_reg   [0:QB];
    logic          dv_ovfx_reg   [0:QB];
    logic          dv_ovfy_reg   [0:QB];
    logic [31:0]   dv_bx_reg     [0:QB];
    logic [31:0]   dv_by_reg     [0:QB];
    logic [DW-1:0] dv_d_reg      [0:QB];
    logic [NW-1:0] dv_rx_reg     [0:QB];
    logic [NW-1:0] dv_ry_reg     [0:QB];
    logic [QB-1:0] dv_qx_reg     [0:QB];
    logic [QB-1:0] dv_qy_reg     [0:QB];

    always_ff @(posedge clk)
    begin
        dv_behind_reg[0] <= s4_behind_reg;
        dv_negx_reg[0]   <= s4_negx_reg;
        dv_negy_reg[0]   <= s4_negy_reg;
        dv_bx_reg[0]     <= s4_bx_reg;
        dv_by_reg[0]     <= s4_by_reg;
        dv_d_reg[0]      <= s4_d_reg;
        dv_rx_reg[0]     <= s4_nx_reg;
        dv_ry_reg[0]     <= s4_ny_reg;
        dv_qx_reg[0]     <= '0;
        dv_qy_reg[0]     <= '0;
        dv_ovfx_reg[0]   <= XW'(s4_nx_reg) >= (XW'(s4_d_reg) << QB);
        dv_ovfy_reg[0]   <= XW'(s4_ny_reg) >= (XW'(s4_d_reg) << QB);
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int unsigned K = QB - 1 - j;
        logic [XW-1:0] dk, rx_ext, ry_ext;
        logic          gex, gey;

        assign dk     = XW'(dv_d_reg[j]) << K;
        assign rx_ext = XW'(dv_rx_reg[j]);
        assign ry_ext = XW'(dv_ry_reg[j]);
        assign gex    = rx_ext >= dk;
        assign gey    = ry_ext >= dk;

        always_ff @(posedge clk)
        begin
            dv_behind_reg[j+1] <= dv_behind_reg[j];
            dv_negx_reg[j+1]   <= dv_negx_reg[j];
            dv_negy_reg[j+1]   <= dv_negy_reg[j];
            dv_ovfx_reg[j+1]   <= dv_ovfx_reg[j];
            dv_ovfy_reg[j+1]   <= dv_ovfy_reg[j];
            dv_bx_reg[j+1]     <= dv_bx_reg[j];
            dv_by_reg[j+1]     <= dv_by_reg[j];
            dv_d_reg[j+1]      <= dv_d_reg[j];
            dv_rx_reg[j+1]     <= gex ? NW'(rx_ext - dk) : dv_rx_reg[j];
            dv_ry_reg[j+1]     <= gey ? NW'(ry_ext - dk) : dv_ry_reg[j];
            dv_qx_reg[j+1]     <= dv_qx_reg[j] | (QB'(gex) << K);
            dv_qy_reg[j+1]     <= dv_qy_reg[j] | (QB'(gey) << K);
        end
    end

    // ---------------- output stage ----------------
    function automatic logic [31:0] pixel(input logic neg, input logic ovf,
                                          input logic [QB-1:0] q, input logic rnz);
        logic signed [QB+1:0] v;
        begin
            v = neg ? -(QB+2)'(q) - (QB+2)'(rnz) : (QB+2)'(q);
            if (ovf)
                pixel = neg ? 32'h8000_0000 : 32'h7fff_ffff;
            else if (v > (QB+2)'(32'sh7fff_ffff))
                pixel = 32'h7fff_ffff;
            else if (v < (QB+2)'(32'sh8000_0000))
                pixel = 32'h8000_0000;
            else
                pixel = v[31:0];
        end
    endfunction

    logic    done_reg;
    screen_t result_reg;

    always_ff @(posedge clk)
    begin
        if (dv_behind_reg[QB])
        begin
            result_reg.screen_x <= dv_bx_reg[QB];
            result_reg.screen_y <= dv_by_reg[QB];
            result_reg.visible  <= 1'b0;
        end
        else
        begin
            result_reg.screen_x <= pixel(dv_negx_reg[QB], dv_ovfx_reg[QB], dv_qx_reg[QB],
                                         dv_rx_reg[QB] != '0);
            result_reg.screen_y <= pixel(dv_negy_reg[QB], dv_ovfy_reg[QB], dv_qy_reg[QB],
                                         dv_ry_reg[QB] != '0);
            result_reg.visible  <= 1'b1;
        end
    end

    // Valid bits travel with the data; nothing ever stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int i = 0; i <= QB; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= start && !busy;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            dv_valid_reg[0] <= s4_valid_reg;
            for (int i = 0; i < QB; i++)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
            done_reg <= dv_valid_reg[QB];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted request produces a done strobe once it has passed through the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after pipeline latency");

    // When the x range check passes, the x divider remainder ends below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[QB] && !dv_behind_reg[QB] && !dv_ovfx_reg[QB])
            |-> (XW'(dv_rx_reg[QB]) < XW'(dv_d_reg[QB])))
        else $error("x divider remainder not reduced");

    // A visible result on the positive side never comes out negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[QB] && !dv_behind_reg[QB] && !dv_negx_reg[QB])
            |=> !result.screen_x[31])
        else $error("nonnegative pixel x came out negative");

endmodule

/* verif/perspective_point_projector_tb.sv */
// Self-checking testbench for the perspective point projector.
`timescale 1ns / 100ps

module perspective_point_projector_tb;
    import ppp_pkg::*;

    localparam int unsigned FRAC = FRAC_BITS_DEFAULT;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;
    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam logic signed [127:0] SAT_MAX = 128'sd2147483647;
    localparam logic signed [127:0] SAT_MIN = -SAT_MAX - 1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    point_t                 point = '0;
    logic                   done;
    screen_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Local copy of the configuration registers.
    logic [63:0]      view_regs [NUM_REGS];
    screen_t          pending_pixels [$];
    int unsigned      idle_percent = 0;
    int unsigned      mismatches = 0;
    int unsigned      points_sent = 0;
    int unsigned      results_checked = 0;
    int unsigned      visible_seen = 0;
    int unsigned      behind_seen = 0;
    longint unsigned  cycle_count = 0;

    perspective_point_projector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] sat32(logic signed [127:0] v);
        if (v > SAT_MAX)
            return SAT_MAX[31:0];
        if (v < SAT_MIN)
            return SAT_MIN[31:0];
        return v[31:0];
    endfunction

    // Row r of the stored matrix (0, 1 or 3 as 0, 1, 2) dotted with (p, 1), floored.
    function automatic logic signed [63:0] clip_value(int r, point_t p);
        logic signed [79:0] m [4];
        logic signed [79:0] pv [3];
        logic signed [79:0] acc;
        m[0] = $signed(view_regs[2*r][31:0]);
        m[1] = $signed(view_regs[2*r][63:32]);
        m[2] = $signed(view_regs[2*r+1][31:0]);
        m[3] = $signed(view_regs[2*r+1][63:32]);
        pv[0] = p.point_x;
        pv[1] = p.point_y;
        pv[2] = p.point_z;
        acc = m[0] * pv[0] + m[1] * pv[1] + m[2] * pv[2] + (m[3] <<< FRAC);
        acc = acc >>> FRAC;
        return acc[63:0];
    endfunction

    // floor(dim * a * 2^FRAC / (2w)), saturated; w is positive here.
    function automatic logic signed [31:0] pixel_coord(logic signed [63:0] a,
                                                       logic signed [63:0] w,
                                                       logic [15:0] dim);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] q;
        num = a;
        num = (num * $signed({1'b0, dim})) <<< FRAC;
        den = w;
        den = den * 2;
        if (num < 0)
        begin
            q = (-num) / den;
            if ((-num) % den != 0)
                q = q + 1;
            q = -q;
        end
        else
            q = num / den;
        return sat32(q);
    endfunction

    function automatic screen_t project_point(point_t p);
        logic signed [63:0]  cx;
        logic signed [63:0]  cy;
        logic signed [63:0]  cw;
        logic signed [127:0] wide;
        screen_t             s;
        cx = clip_value(0, p);
        cy = clip_value(1, p);
        cw = clip_value(2, p);
        wide = cw;
        if (cw <= 0 || wide * 1000 < (128'sd1 <<< FRAC))
        begin
            wide = cx;
            s.screen_x = sat32(wide * 100000);
            wide = cy;
            s.screen_y = sat32(wide * 100000);
            s.visible = 1'b0;
        end
        else
        begin
            s.screen_x = pixel_coord(cw + cx, cw, view_regs[REG_SCREEN][15:0]);
            s.screen_y = pixel_coord(cw - cy, cw, view_regs[REG_SCREEN][31:16]);
            s.visible = 1'b1;
        end
        return s;
    endfunction

    // Every accepted request gets its expected result queued.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_pixels.push_back(project_point(point));
    end

    always @(posedge clk)
    begin
        screen_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d vis=%0b",
                             result.screen_x, result.screen_y, result.visible);
            end
            else
            begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (want.visible)
                    visible_seen++;
                else
                    behind_seen++;
                if (result.screen_x !== want.screen_x || result.screen_y !== want.screen_y ||
                    result.visible !== want.visible)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
                                 want.screen_x, want.screen_y, want.visible,
                                 result.screen_x, result.screen_y, result.visible);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_point(point_t p);
        logic stalled;
        start <= 1'b1;
        point <= p;
        do
        begin
            @(negedge clk);
            stalled = busy;
            @(posedge clk);
        end
        while (stalled);
        points_sent++;
        if ($urandom_range(99) < idle_percent)
        begin
            start <= 1'b0;
            while ($urandom_range(99) < idle_percent)
                @(posedge clk);
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        if (idx < NUM_REGS)
            view_regs[idx] = (idx == REG_SCREEN) ? {32'b0, value[31:0]} : value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] matrix_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            3: return 32'h0;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] coord_word();
        case ($urandom_range(7))
            0, 1: return $urandom();
            2: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7fff_ffff : 32'h0);
            default: return $urandom_range(32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.point_x = coord_word();
        p.point_y = coord_word();
        p.point_z = coord_word();
        // Mostly in front of a camera that looks down +z.
        if ($urandom_range(3) != 0)
            p.point_z = $urandom_range(32'h0040_0000, 32'h0000_0100);
        return p;
    endfunction

    // A camera-like matrix whose w row follows z, or a fully random one.
    task automatic load_view(bit camera, logic [31:0] screen);
        logic [31:0] w[12];
        foreach (w[i])
            w[i] = matrix_word();
        if (camera)
        begin
            w[8] = $urandom_range(32'h0000_4000) - 32'h0000_2000;
            w[9] = $urandom_range(32'h0000_4000) - 32'h0000_2000;
            w[10] = $urandom_range(32'h0002_0000, 32'h0000_8000);
            w[11] = $urandom_range(32'h0001_0000);
        end
        for (int r = 0; r < 6; r++)
            write_reg(cfg_reg_t'(r), {w[2*r+1], w[2*r]});
        write_reg(REG_SCREEN, screen);
    endtask

    task automatic test_directed();
        point_t p;
        // Identity rows, w taken from z.
        write_reg(REG_ROW0_LO, {32'h0, 32'h0001_0000});
        write_reg(REG_ROW0_HI, 64'h0);
        write_reg(REG_ROW1_LO, {32'h0001_0000, 32'h0});
        write_reg(REG_ROW1_HI, 64'h0);
        write_reg(REG_ROW3_LO, 64'h0);
        write_reg(REG_ROW3_HI, {32'h0, 32'h0001_0000});
        write_reg(REG_SCREEN, {16'd1080, 16'd1920});
        // A write to the unused index must change nothing.
        write_reg(UNUSED_INDEX, 64'hffff_ffff_ffff_ffff);
        send_point('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
        send_point('{32'h0, 32'h0, 32'h0});                      // w zero
        send_point('{32'h0000_8000, 32'h0, 32'h0000_0041});      // w just below 0.001
        send_point('{32'h0000_8000, 32'hffff_8000, 32'h0000_0042}); // w just above
        send_point('{32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000}); // w negative
        send_point('{32'h0000_5000, 32'hffff_b000, 32'hffff_ffff});
        send_point('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        send_point('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0100});
        send_point('{32'hffff_ffff, 32'h0000_0001, 32'h0001_0000});
        wait_drained();
        // Zero screen size and the largest screen.
        write_reg(REG_SCREEN, 32'h0);
        send_point('{32'h0000_8000, 32'h0000_4000, 32'h0002_0000});
        send_point('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0042});
        wait_drained();
        write_reg(REG_SCREEN, 32'hffff_ffff);
        send_point('{32'h0000_8000, 32'h0000_4000, 32'h0002_0000});
        send_point('{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0042});
        wait_drained();
        // Extreme matrix words everywhere.
        for (int r = 0; r < 6; r++)
            write_reg(cfg_reg_t'(r), {2{32'h8000_0000}});
        send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_point('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        wait_drained();
        for (int r = 0; r < 6; r++)
            write_reg(cfg_reg_t'(r), {2{32'h7fff_ffff}});
        send_point('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        p = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0000};
        send_point(p);
        wait_drained();
    endtask

    task automatic test_random_phase(int unsigned idle, int unsigned items);
        logic [31:0] screens[4];
        screens = '{32'h0, 32'hffff_ffff, {16'd1080, 16'd1920}, $urandom()};
        idle_percent = idle;
        for (int blk = 0; blk < 3; blk++)
        begin
            load_view($urandom_range(4) != 0, screens[$urandom_range(3)]);
            for (int i = 0; i < items / 3; i++)
                send_point(random_point());
            wait_drained();
        end
    endtask

    initial
    begin
        foreach (view_regs[i])
            view_regs[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 450);
        test_random_phase(73, 450);
        test_random_phase(25, 450);
        test_random_phase(0, 450);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_pixels.size();
        $display("Projected %0d points under directed and random view matrices and screens,",
                 points_sent);
        $display("with %0d on-screen and %0d behind-camera results checked.",
                 visible_seen, behind_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
